@@ rtl/mbps_pkg.sv @@
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// payload structs, configuration register codes and default sizes
// no dependencies
package mbps_pkg;

	localparam int MaxPatternBytesDef = 32;
	localparam int PatternWords       = 4;
	localparam int CfgDataWidth       = 64;
	localparam int CfgIndexWidth      = 3;
	localparam int AddrWidth          = 48;
	localparam int OffsetWidth        = 32;
	localparam int LengthWidth        = 6;

	typedef enum logic [CfgIndexWidth-1:0] {
		REG_PATTERN_WORD_0 = 3'd0,
		REG_PATTERN_WORD_1 = 3'd1,
		REG_PATTERN_WORD_2 = 3'd2,
		REG_PATTERN_WORD_3 = 3'd3,
		REG_CARE_MASK      = 3'd4,
		REG_PATTERN_LENGTH = 3'd5,
		REG_RESULT_OFFSET  = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]           data_byte;
		logic [AddrWidth-1:0] byte_address;
		logic                 is_last;
	} scan_item_t;

	typedef struct packed {
		logic                 found;
		logic [AddrWidth-1:0] match_address;
	} result_item_t;

endpackage

@@ rtl/masked_byte_pattern_scanner.sv @@
// Masked byte pattern scanner: one byte per cycle is accepted while the input is not stalled;
// each byte is held in an input register, where the shifted window is compared with the pattern
// at all positions at once, and the result lands in an output register. Sustained rate is one
// byte per clock when not stalled, set by the compare of the window against a pre-aligned copy
// of the pattern. The aligned pattern is rebuilt from the configuration registers into its own
// register after a write. The input stalls only while a result is due and the output register
// is full and stalled.
// depends on mbps_pkg
module masked_byte_pattern_scanner import mbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = MaxPatternBytesDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CfgIndexWidth-1:0] cfg_index,
	input  logic [CfgDataWidth-1:0]  cfg_data,
	input  logic                     scan_valid,
	output logic                     scan_stall,
	input  scan_item_t               scan_item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output result_item_t             result_item
);

	localparam int LW = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int WB = 8 * MAX_PATTERN_BYTES;

	// configuration registers
	logic [CfgDataWidth-1:0] pattern_word_q [PatternWords];
	logic [31:0]             care_mask_q;
	logic [LengthWidth-1:0]  pattern_length_q;
	logic [OffsetWidth-1:0]  result_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < PatternWords; w++) pattern_word_q[w] <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= LengthWidth'(1);
			result_offset_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_WORD_0: pattern_word_q[0] <= cfg_data;
				REG_PATTERN_WORD_1: pattern_word_q[1] <= cfg_data;
				REG_PATTERN_WORD_2: pattern_word_q[2] <= cfg_data;
				REG_PATTERN_WORD_3: pattern_word_q[3] <= cfg_data;
				REG_CARE_MASK:      care_mask_q      <= cfg_data[31:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LengthWidth-1:0];
				REG_RESULT_OFFSET:  result_offset_q  <= cfg_data[OffsetWidth-1:0];
				default: ;
			endcase
		end
	end

	// effective length and pattern aligned to window positions
	// window byte k lines up with pattern byte len-1-k
	logic [LW-1:0]                len_eff;
	logic [LW-1:0]                align_shift;
	logic [WB-1:0]                pat_rev;
	logic [MAX_PATTERN_BYTES-1:0] care_rev;
	logic [WB-1:0]                aligned_pat_q;
	logic [MAX_PATTERN_BYTES-1:0] aligned_care_q;
	logic [LW-1:0]                len_q;

	always_comb begin
		if (pattern_length_q == '0)
			len_eff = LW'(1);
		else if (int'(pattern_length_q) > MAX_PATTERN_BYTES)
			len_eff = LW'(MAX_PATTERN_BYTES);
		else
			len_eff = LW'(pattern_length_q);
		align_shift = LW'(MAX_PATTERN_BYTES) - len_eff;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			pat_rev[8*(MAX_PATTERN_BYTES-1-j) +: 8] =
				pattern_word_q[j/8][8*(j%8) +: 8];
			care_rev[MAX_PATTERN_BYTES-1-j] = care_mask_q[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_pat_q  <= '0;
			aligned_care_q <= '0;
			len_q          <= LW'(1);
		end else begin
			aligned_pat_q  <= pat_rev >> {align_shift, 3'b000};
			aligned_care_q <= care_rev >> align_shift;
			len_q          <= len_eff;
		end
	end

	// input register
	logic       valid_s1;
	scan_item_t item_s1;
	logic       adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!scan_stall) begin
			valid_s1 <= scan_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!scan_stall && scan_valid) begin
			item_s1 <= scan_item;
		end
	end

	// region state
	logic [WB-1:0] window_q;
	logic [LW-1:0] bytes_seen_q;
	logic          match_latched_q;

	logic [WB-1:0]                win_n;
	logic [LW-1:0]                seen_n;
	logic [MAX_PATTERN_BYTES-1:0] byte_ok;
	logic                         hit;
	logic                         has_result;
	logic                         out_free;
	logic [AddrWidth-1:0]         match_addr;

	always_comb begin
		win_n  = {window_q[WB-9:0], item_s1.data_byte};
		seen_n = (int'(bytes_seen_q) < MAX_PATTERN_BYTES) ? bytes_seen_q + LW'(1)
			: bytes_seen_q;
		for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
			byte_ok[k] = !aligned_care_q[k] || (win_n[8*k +: 8] == aligned_pat_q[8*k +: 8]);
		end
		hit        = !match_latched_q && (seen_n >= len_q) && (&byte_ok);
		has_result = !match_latched_q && (hit || item_s1.is_last);
		match_addr = item_s1.byte_address - AddrWidth'(len_q - LW'(1))
			+ {{(AddrWidth-OffsetWidth){result_offset_q[OffsetWidth-1]}}, result_offset_q};
	end

	assign out_free   = !result_valid || !result_stall;
	assign adv        = valid_s1 && (!has_result || out_free);
	assign scan_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= '0;
			bytes_seen_q    <= '0;
			match_latched_q <= 1'b0;
		end else if (adv) begin
			if (item_s1.is_last) begin
				window_q        <= '0;
				bytes_seen_q    <= '0;
				match_latched_q <= 1'b0;
			end else if (!match_latched_q) begin
				window_q        <= win_n;
				bytes_seen_q    <= seen_n;
				match_latched_q <= hit;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && has_result) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_result) begin
			result_item.found         <= hit;
			result_item.match_address <= hit ? match_addr : '0;
		end
	end

endmodule

@@ rtl/mbps_checker.sv @@
// mbps_checker: port-level assertions for the masked byte pattern scanner
// bound to masked_byte_pattern_scanner; depends on mbps_pkg
module mbps_checker import mbps_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     scan_valid,
	input logic                     scan_stall,
	input scan_item_t               scan_item,
	input logic                     result_valid,
	input logic                     result_stall,
	input result_item_t             result_item
);

	// a stalled result transfer keeps its valid and payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result changed while stalled");

	// not-found results carry a zero address
	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_item.found |-> result_item.match_address == '0)
		else $error("not-found result with nonzero address");

	// input backpressure only comes from a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stall |-> result_valid && result_stall)
		else $error("input stalled while output could take a transfer");

	// a stalled input transfer keeps its valid and payload
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scan_valid && scan_stall |=> scan_valid && $stable(scan_item))
		else $error("input changed while stalled");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
